FILE: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// condition holds on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, cond) \
   label: assert property (@(posedge clk) (cond)) else $error("assertion failed");

`endif

FILE: hdl/sdd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdd_pkg
// shared constants, types and the hash function of the duplicate detector
// ----------------------------------------------------------------------------
package sdd_pkg;

   localparam int CAPACITY = 256;
   localparam int ADDR_W   = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam logic [ADDR_W:0]   CAP_EXT   = (ADDR_W+1)'(CAPACITY);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CAPACITY - 1);

   // one queued work item
   typedef struct packed {
      logic [31:0]       value;
      logic [ADDR_W-1:0] hash;
      logic              has_value;
      logic              is_last;
   } item_type;

   // queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // fold the value into a table index below CAPACITY
   function automatic logic [ADDR_W-1:0] hash_index(logic [31:0] v);
      logic [ADDR_W-1:0] f;
      f = '0;
      for (int i = 0; i < 32; i++) begin
         f[i % ADDR_W] = f[i % ADDR_W] ^ v[i];
      end
      if ({1'b0, f} >= CAP_EXT) begin
         f = f - CAP_EXT[ADDR_W-1:0];
      end
      return f;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/sdd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdd_front
// accepts input beats, drops empty non-last beats and hashes the value
// ----------------------------------------------------------------------------
module sdd_front import sdd_pkg::*; (
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [31:0]      req_tdata,   // value[31:0]
   input  wire logic             req_tuser,   // has_value
   input  wire logic             req_tlast,   // is_last
   input  wire queue_status_type q_status,
   output logic                  push,
   output item_type              push_item
);

   // accept while the queue has room
   assign req_tready = !q_status.full;

   // only beats that carry a value or end an array do any work
   assign push = req_tvalid && req_tready && (req_tuser || req_tlast);

   // classify and hash
   always_comb begin
      push_item.value     = req_tdata;
      push_item.hash      = hash_index(req_tdata);
      push_item.has_value = req_tuser;
      push_item.is_last   = req_tlast;
   end

endmodule
`default_nettype wire

FILE: hdl/sdd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdd_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module sdd_queue import sdd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire item_type   push_item,
   input  wire logic       pop,
   output item_type        pop_item,
   output queue_status_type status
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_item     = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/sdd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdd_back
// probes the open-addressed hash set, inserts new values, reports per array
// ----------------------------------------------------------------------------
module sdd_back import sdd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type q_status,
   input  wire item_type         pop_item,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [7:0]            rsp_tdata    // found_duplicate, overflowed, zero pad
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_CMP,
      S_EMIT
   } state_type;

   state_type         state_ff, state_in;
   item_type          item_ff, item_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] probes_ff, probes_in;
   logic              dup_ff, dup_in;
   logic              ovf_ff, ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_data_ff, rsp_data_in;
   logic              valid_ff [CAPACITY];
   logic [31:0]       mem [CAPACITY];
   logic [31:0]       rd_data_ff;
   logic              hit, slot_free, wr_en, clear_all;

   assign pop        = (state_ff == S_IDLE) && !q_status.empty;
   assign hit        = valid_ff[addr_ff] && (rd_data_ff == item_ff.value);
   assign slot_free  = !valid_ff[addr_ff];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   // probe sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      addr_in      = addr_ff;
      probes_in    = probes_ff;
      dup_in       = dup_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      clear_all    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               item_in   = pop_item;
               addr_in   = pop_item.hash;
               probes_in = '0;
               if (pop_item.has_value && !dup_ff) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            state_in = item_ff.is_last ? S_EMIT : S_IDLE;
            if (hit) begin
               dup_in = 1'b1;
            end else if (slot_free) begin
               wr_en = 1'b1;
            end else if (probes_ff == LAST_ADDR) begin
               ovf_in = 1'b1;
            end else begin
               addr_in   = (addr_ff == LAST_ADDR) ? '0 : addr_ff + 1'b1;
               probes_in = probes_ff + 1'b1;
               state_in  = S_READ;
            end
         end
         S_EMIT: begin
            if (!item_ff.is_last) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {ovf_ff, dup_ff};
               dup_in       = 1'b0;
               ovf_in       = 1'b0;
               clear_all    = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dup_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dup_ff       <= dup_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      addr_ff     <= addr_in;
      probes_ff   <= probes_in;
      rsp_data_ff <= rsp_data_in;
   end

   // per-entry valid bits, cleared together at the end of an array
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (reset || clear_all) begin
            valid_ff[i] <= 1'b0;
         end else if (wr_en && (addr_ff == ADDR_W'(i))) begin
            valid_ff[i] <= 1'b1;
         end
      end
   end

   // value store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr_ff] <= item_ff.value;
      end
      rd_data_ff <= mem[addr_ff];
   end

endmodule
`default_nettype wire

FILE: hdl/stream_duplicate_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stream_duplicate_detector
// reports whether a streamed array of 32-bit values holds a duplicate
// ----------------------------------------------------------------------------
// Each req beat carries one signed element in tdata, tuser=1 when the beat
// holds a real element and tlast on the final beat of an array. The final
// beat yields one rsp beat with found_duplicate in bit 0 and overflowed in
// bit 1. Values go into an open-addressed hash set of CAPACITY entries in a
// single-port-read memory, probing on to the next slot on a collision, and
// a final beat then posts its result and clears the set. A two-beat queue
// lets the input keep flowing while the prober is busy, and the result
// register holds one answer until taken.
`include "assert_macros.svh"
module stream_duplicate_detector import sdd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // value[31:0]
   input  wire logic        req_tuser,   // has_value
   input  wire logic        req_tlast,   // is_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // found_duplicate, overflowed, zero pad
);

   queue_status_type q_status;
   item_type         push_item, pop_item;
   logic             push, pop;

   // accept and classify
   sdd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .push_item  (push_item)
   );

   // decoupling queue
   sdd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   // probe engine and result register
   sdd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // checks
   `ASSERT_IMPLIES(a_queue_sane, clock, reset, 1'b1, !(q_status.full && q_status.empty))
   `ASSERT_IMPLIES(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[7:2] == 6'd0)
   `ASSERT_IMPLIES(a_pop_nonempty, clock, reset, pop, !q_status.empty)
   `ASSERT_IMPLIES(a_ready_room, clock, reset, req_tready, !q_status.full)

endmodule
`default_nettype wire
